// File: rtl/jot_pkg.sv
// jot_pkg: shared codes, character constants and the result record of the json object tokenizer
// no dependencies; used by jot_step and json_object_tokenizer
package jot_pkg;

	localparam int StateW = 4;

	localparam logic [StateW-1:0] ST_START    = 4'd0;
	localparam logic [StateW-1:0] ST_BEGIN    = 4'd1;
	localparam logic [StateW-1:0] ST_KEY      = 4'd2;
	localparam logic [StateW-1:0] ST_KEYEND   = 4'd3;
	localparam logic [StateW-1:0] ST_STARTVAL = 4'd4;
	localparam logic [StateW-1:0] ST_STRVAL   = 4'd5;
	localparam logic [StateW-1:0] ST_BOOL     = 4'd6;
	localparam logic [StateW-1:0] ST_NUM      = 4'd7;
	localparam logic [StateW-1:0] ST_STREND   = 4'd8;
	localparam logic [StateW-1:0] ST_END      = 4'd9;

	localparam logic [1:0] VT_STRING = 2'd0;
	localparam logic [1:0] VT_NUMBER = 2'd1;
	localparam logic [1:0] VT_BOOL   = 2'd2;

	localparam logic [7:0] CH_LBRACE = 8'h7B;
	localparam logic [7:0] CH_RBRACE = 8'h7D;
	localparam logic [7:0] CH_QUOTE  = 8'h22;
	localparam logic [7:0] CH_COLON  = 8'h3A;
	localparam logic [7:0] CH_COMMA  = 8'h2C;
	localparam logic [7:0] CH_MINUS  = 8'h2D;
	localparam logic [7:0] CH_DOT    = 8'h2E;
	localparam logic [7:0] CH_ZERO   = 8'd48;
	localparam logic [7:0] CH_NINE   = 8'd57;
	localparam logic [7:0] CH_T      = 8'h74;
	localparam logic [7:0] CH_F      = 8'h66;

	typedef struct packed {
		logic [StateW-1:0] parse_state_out;
		logic              store_valid;
		logic [5:0]        store_addr;
		logic [7:0]        store_byte;
		logic              entry_done;
		logic [2:0]        entry_index;
		logic [5:0]        key_offset;
		logic [5:0]        value_offset;
		logic [1:0]        value_type;
		logic              overflow;
	} jot_result_t;

	function automatic logic is_num_char(input logic [7:0] c);
		return (c == CH_MINUS) || (c == CH_DOT) || ((c >= CH_ZERO) && (c <= CH_NINE));
	endfunction

endpackage

// File: rtl/jot_if.sv
// jot_if: valid/ready channel interfaces for characters in and tokenizer results out
// depends on nothing; used by json_object_tokenizer
interface jot_chr_if;
	logic       valid;
	logic       ready;
	logic [7:0] byte_in;
	logic       restart;

	modport source (output valid, output byte_in, output restart, input ready);
	modport sink (input valid, input byte_in, input restart, output ready);
endinterface

interface jot_tok_if;
	logic       valid;
	logic       ready;
	logic [3:0] parse_state_out;
	logic       store_valid;
	logic [5:0] store_addr;
	logic [7:0] store_byte;
	logic       entry_done;
	logic [2:0] entry_index;
	logic [5:0] key_offset;
	logic [5:0] value_offset;
	logic [1:0] value_type;
	logic       overflow;

	modport source (output valid, output parse_state_out, output store_valid,
		output store_addr, output store_byte, output entry_done, output entry_index,
		output key_offset, output value_offset, output value_type, output overflow,
		input ready);
	modport sink (input valid, input parse_state_out, input store_valid,
		input store_addr, input store_byte, input entry_done, input entry_index,
		input key_offset, input value_offset, input value_type, input overflow,
		output ready);
endinterface

// File: rtl/jot_step.sv
// jot_step: combinational next-state and result logic for one character
// depends on jot_pkg
module jot_step #(
	parameter int DATA_BYTES  = 64,
	parameter int MAX_ENTRIES = 8,
	parameter int DCW = 7,
	parameter int ECW = 4
) (
	input  logic [7:0]                 byte_in,
	input  logic                       restart,
	input  logic [jot_pkg::StateW-1:0] state,
	input  logic [DCW-1:0]             data_count,
	input  logic [ECW-1:0]             entry_count,
	input  logic [5:0]                 key_off,
	input  logic [5:0]                 val_off,
	input  logic [1:0]                 val_type,
	input  logic                       ovf,
	output logic [jot_pkg::StateW-1:0] state_nxt,
	output logic [DCW-1:0]             data_count_nxt,
	output logic [ECW-1:0]             entry_count_nxt,
	output logic [5:0]                 key_off_nxt,
	output logic [5:0]                 val_off_nxt,
	output logic [1:0]                 val_type_nxt,
	output logic                       ovf_nxt,
	output jot_pkg::jot_result_t       res
);
	import jot_pkg::*;

	logic [StateW-1:0] st;
	logic [DCW-1:0]    dc;
	logic [ECW-1:0]    ec;
	logic [5:0]        ko;
	logic [5:0]        vo;
	logic [1:0]        vt;
	logic              ov;
	logic              wr_req;
	logic [7:0]        wr_byte;
	logic              fin_req;
	logic              wr_ok;
	logic              fin_ok;

	// restart clears everything ahead of this character
	assign st = restart ? ST_START : state;
	assign dc = restart ? '0 : data_count;
	assign ec = restart ? '0 : entry_count;
	assign ko = restart ? '0 : key_off;
	assign vo = restart ? '0 : val_off;
	assign vt = restart ? VT_STRING : val_type;
	assign ov = restart ? 1'b0 : ovf;

	always_comb begin
		state_nxt    = st;
		key_off_nxt  = ko;
		val_off_nxt  = vo;
		val_type_nxt = vt;
		wr_req       = 1'b0;
		wr_byte      = byte_in;
		fin_req      = 1'b0;
		case (st)
			ST_START: begin
				if (byte_in == CH_LBRACE) state_nxt = ST_BEGIN;
			end
			ST_BEGIN: begin
				if (byte_in == CH_QUOTE) begin
					key_off_nxt = dc[5:0];
					state_nxt   = ST_KEY;
				end
			end
			ST_KEY: begin
				wr_req = 1'b1;
				if (byte_in == CH_QUOTE) begin
					wr_byte   = 8'd0;
					state_nxt = ST_KEYEND;
				end
			end
			ST_KEYEND: begin
				if (byte_in == CH_COLON) state_nxt = ST_STARTVAL;
			end
			ST_STARTVAL: begin
				if (byte_in == CH_QUOTE) begin
					val_off_nxt  = dc[5:0];
					val_type_nxt = VT_STRING;
					state_nxt    = ST_STRVAL;
				end else if (byte_in == CH_T || byte_in == CH_F) begin
					val_off_nxt  = dc[5:0];
					val_type_nxt = VT_BOOL;
					wr_req       = 1'b1;
					state_nxt    = ST_BOOL;
				end else if (is_num_char(byte_in)) begin
					val_off_nxt  = dc[5:0];
					val_type_nxt = VT_NUMBER;
					wr_req       = 1'b1;
					state_nxt    = ST_NUM;
				end
			end
			ST_STRVAL: begin
				wr_req = 1'b1;
				if (byte_in == CH_QUOTE) begin
					wr_byte   = 8'd0;
					fin_req   = 1'b1;
					state_nxt = ST_STREND;
				end
			end
			ST_STREND: begin
				if (byte_in == CH_COMMA) state_nxt = ST_BEGIN;
				else if (byte_in == CH_RBRACE) state_nxt = ST_END;
			end
			ST_NUM, ST_BOOL: begin
				if (byte_in == CH_COMMA || byte_in == CH_RBRACE) begin
					wr_req    = 1'b1;
					wr_byte   = 8'd0;
					fin_req   = 1'b1;
					state_nxt = (byte_in == CH_COMMA) ? ST_BEGIN : ST_END;
				end else if (st == ST_NUM && is_num_char(byte_in)) begin
					wr_req = 1'b1;
				end
			end
			default: state_nxt = ST_END;
		endcase
	end

	assign fin_ok = ec < ECW'(MAX_ENTRIES);
	assign wr_ok  = (dc < DCW'(DATA_BYTES)) && fin_ok;

	assign data_count_nxt  = (wr_req && wr_ok) ? dc + 1'b1 : dc;
	assign entry_count_nxt = (fin_req && fin_ok) ? ec + 1'b1 : ec;
	assign ovf_nxt         = ov | (wr_req && !wr_ok) | (fin_req && !fin_ok);

	always_comb begin
		res                 = '0;
		res.parse_state_out = state_nxt;
		res.overflow        = ovf_nxt;
		if (wr_req && wr_ok) begin
			res.store_valid = 1'b1;
			res.store_addr  = dc[5:0];
			res.store_byte  = wr_byte;
		end
		if (fin_req && fin_ok) begin
			res.entry_done   = 1'b1;
			res.entry_index  = ec[2:0];
			res.key_offset   = ko;
			res.value_offset = vo;
			res.value_type   = vt;
		end
	end

endmodule

// File: rtl/json_object_tokenizer.sv
// json_object_tokenizer: byte-serial tokenizer for a flat json object, top level
// depends on jot_pkg, jot_if (jot_chr_if, jot_tok_if) and jot_step
//
// channel | dir | payload
// chr     | in  | byte_in, restart
// tok     | out | parse_state_out, store_valid/addr/byte, entry_done/index,
//         |     | key_offset, value_offset, value_type, overflow
//
// one character per cycle while tok is not stalled; from accept to result: input register,
// then the step logic into the result register, which also updates the context
// arst_n clears both valid bits and the parse context (start state, zero counts)
// a stalled result holds in its register; the input register still takes a beat
// while the result register drains in the same cycle
module json_object_tokenizer #(
	parameter int DATA_BYTES  = 64,
	parameter int MAX_ENTRIES = 8
) (
	input logic clk,
	input logic arst_n,
	jot_chr_if.sink   chr,
	jot_tok_if.source tok
);
	import jot_pkg::*;

	localparam int DCB = $clog2(DATA_BYTES + 1);
	localparam int ECB = $clog2(MAX_ENTRIES + 1);
	localparam int DCW = (DCB > 6) ? DCB : 6;
	localparam int ECW = (ECB > 3) ? ECB : 3;

	logic              in_valid_s1;
	logic [7:0]        byte_s1;
	logic              restart_s1;
	logic              out_valid_s2;
	jot_result_t       res_s2;
	jot_result_t       res_nxt;
	logic              adv;

	logic [StateW-1:0] state_q, state_nxt;
	logic [DCW-1:0]    data_count_q, data_count_nxt;
	logic [ECW-1:0]    entry_count_q, entry_count_nxt;
	logic [5:0]        key_off_q, key_off_nxt;
	logic [5:0]        val_off_q, val_off_nxt;
	logic [1:0]        val_type_q, val_type_nxt;
	logic              ovf_q, ovf_nxt;

	assign adv       = in_valid_s1 && (!out_valid_s2 || tok.ready);
	assign chr.ready = !in_valid_s1 || adv;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			in_valid_s1 <= 1'b0;
		end else if (chr.ready) begin
			in_valid_s1 <= chr.valid;
		end
	end

	always_ff @(posedge clk) begin
		if (chr.ready && chr.valid) begin
			byte_s1    <= chr.byte_in;
			restart_s1 <= chr.restart;
		end
	end

	jot_step #(
		.DATA_BYTES  (DATA_BYTES),
		.MAX_ENTRIES (MAX_ENTRIES),
		.DCW         (DCW),
		.ECW         (ECW)
	) u_step (
		.byte_in         (byte_s1),
		.restart         (restart_s1),
		.state           (state_q),
		.data_count      (data_count_q),
		.entry_count     (entry_count_q),
		.key_off         (key_off_q),
		.val_off         (val_off_q),
		.val_type        (val_type_q),
		.ovf             (ovf_q),
		.state_nxt       (state_nxt),
		.data_count_nxt  (data_count_nxt),
		.entry_count_nxt (entry_count_nxt),
		.key_off_nxt     (key_off_nxt),
		.val_off_nxt     (val_off_nxt),
		.val_type_nxt    (val_type_nxt),
		.ovf_nxt         (ovf_nxt),
		.res             (res_nxt)
	);

	// parse context moves only when the beat leaves for the result register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q       <= ST_START;
			data_count_q  <= '0;
			entry_count_q <= '0;
			key_off_q     <= '0;
			val_off_q     <= '0;
			val_type_q    <= VT_STRING;
			ovf_q         <= 1'b0;
		end else if (adv) begin
			state_q       <= state_nxt;
			data_count_q  <= data_count_nxt;
			entry_count_q <= entry_count_nxt;
			key_off_q     <= key_off_nxt;
			val_off_q     <= val_off_nxt;
			val_type_q    <= val_type_nxt;
			ovf_q         <= ovf_nxt;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_s2 <= 1'b0;
		end else if (adv) begin
			out_valid_s2 <= 1'b1;
		end else if (tok.ready) begin
			out_valid_s2 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			res_s2 <= res_nxt;
		end
	end

	assign tok.valid           = out_valid_s2;
	assign tok.parse_state_out = res_s2.parse_state_out;
	assign tok.store_valid     = res_s2.store_valid;
	assign tok.store_addr      = res_s2.store_addr;
	assign tok.store_byte      = res_s2.store_byte;
	assign tok.entry_done      = res_s2.entry_done;
	assign tok.entry_index     = res_s2.entry_index;
	assign tok.key_offset      = res_s2.key_offset;
	assign tok.value_offset    = res_s2.value_offset;
	assign tok.value_type      = res_s2.value_type;
	assign tok.overflow        = res_s2.overflow;

endmodule
